[hw/rtl/mfcc_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the mailbox frame checker.
// No dependencies.
`timescale 1ns / 1ps

package mfcc_pkg;

    localparam int MAILBOX_BYTES_DEF = 256;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam int HEADER_BYTES = 3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] computed_check;
        logic [7:0] received_check;
    } verdict_t;

    // MSB-first CRC-8 over one byte; eight shallow xor steps on 8 bits
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hw/rtl/mailbox_frame_crc8_checker_unit.sv]
// Top level of the mailbox frame CRC-8 checker: stream ports and the result register.
// Depends on mfcc_pkg and mfcc_frame_tracker.
`timescale 1ns / 1ps

// A frame's verdict shows on m_tvalid in the cycle after its last byte transfers.
// Throughput: one byte per cycle while s_tready is high; the CRC byte update
// and verdict sit between the frame state registers and the result register.
// s_tready is high whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous) clears the frame state and drops any pending result.
module mailbox_frame_crc8_checker_unit #(
    parameter int MAILBOX_BYTES = mfcc_pkg::MAILBOX_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mfcc_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] mailbox_byte
    input  logic                               s_tlast,  // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] frame_status, [9:2] command_code, [17:10] payload_length,
    // [25:18] computed_check, [33:26] received_check, [39:34] zero
    output logic [mfcc_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import mfcc_pkg::*;

    logic     take;
    verdict_t verdict;
    logic     valid_reg;
    verdict_t result_reg;

    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    mfcc_frame_tracker #(
        .MAILBOX_BYTES(MAILBOX_BYTES)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .mailbox_byte(s_tdata[7:0]),
        .last_byte   (s_tlast),
        .verdict     (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take && s_tlast)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
            result_reg <= verdict;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0,
                       result_reg.received_check,
                       result_reg.computed_check,
                       result_reg.payload_length,
                       result_reg.command_code,
                       result_reg.frame_status};

endmodule

[hw/rtl/mfcc_frame_tracker.sv]
// Frame state (position, header bytes, running CRC) and the verdict for the current byte.
// Depends on mfcc_pkg.
`timescale 1ns / 1ps

module mfcc_frame_tracker #(
    parameter int MAILBOX_BYTES = mfcc_pkg::MAILBOX_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        mailbox_byte,
    input  logic              last_byte,
    output mfcc_pkg::verdict_t verdict
);
    import mfcc_pkg::*;

    localparam int POS_W = $clog2(MAILBOX_BYTES + 1);
    localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 2;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAILBOX_BYTES);
    localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);

    logic [POS_W-1:0] position_reg, position_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       check_reg, check_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       size_reg, size_next;
    logic [7:0]       crc_fed;
    logic [CMP_W-1:0] frame_end;

    assign crc_fed = crc8_update(crc_reg, mailbox_byte);

    always_comb
    begin
        position_next = position_reg;
        crc_next      = crc_reg;
        check_next    = check_reg;
        command_next  = command_reg;
        size_next     = size_reg;
        // drop bytes once the mailbox is full
        if (position_reg < POS_MAX)
        begin
            position_next = position_reg + POS_W'(1);
            if (position_reg == '0)
                check_next = mailbox_byte;
            else if (position_reg == POS_W'(1))
            begin
                command_next = mailbox_byte;
                crc_next     = crc_fed;
            end
            else if (position_reg == POS_W'(2))
            begin
                size_next = mailbox_byte;
                crc_next  = crc_fed;
            end
            else if (CMP_W'(position_reg - POS_HDR) < CMP_W'(size_reg))
                crc_next = crc_fed;
        end
    end

    assign frame_end = CMP_W'(HEADER_BYTES) + CMP_W'(size_next);

    always_comb
    begin
        if (position_next < POS_HDR)
            verdict.frame_status = STATUS_SHORT;
        else if (CMP_W'(position_next) < frame_end)
            verdict.frame_status = STATUS_TRUNCATED;
        else if (crc_next != check_next)
            verdict.frame_status = STATUS_CRC_ERR;
        else
            verdict.frame_status = STATUS_OK;
        verdict.command_code   = command_next;
        verdict.payload_length = size_next;
        verdict.computed_check = crc_next;
        verdict.received_check = check_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            check_reg    <= '0;
            command_reg  <= '0;
            size_reg     <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                // clear for the next frame
                position_reg <= '0;
                crc_reg      <= CRC_INIT;
                check_reg    <= '0;
                command_reg  <= '0;
                size_reg     <= '0;
            end
            else
            begin
                position_reg <= position_next;
                crc_reg      <= crc_next;
                check_reg    <= check_next;
                command_reg  <= command_next;
                size_reg     <= size_next;
            end
        end
    end

endmodule

[hw/rtl/mfcc_checker.sv]
// Port-level assertions for the mailbox frame checker, bound to the top level.
// Depends on mfcc_pkg and mailbox_frame_crc8_checker_unit.
`timescale 1ns / 1ps

module mfcc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mfcc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mfcc_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a last-byte transfer always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // a non-last transfer creates no result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !(m_tvalid && m_tready)
        |=> m_tvalid == $past(m_tvalid))
        else $error("result invented on non-last byte");

    // input side never blocks while the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind mailbox_frame_crc8_checker_unit mfcc_checker u_mfcc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
